@@ design/longest_subarray_with_target_sum_top_macros.svh @@
// Assertion macros shared by the longest-subarray block.
// No dependencies; included by modules that assert.
`ifndef LONGEST_SUBARRAY_WITH_TARGET_SUM_TOP_MACROS_SVH
`define LONGEST_SUBARRAY_WITH_TARGET_SUM_TOP_MACROS_SVH

// Property must hold at every edge outside reset.
`define LSTS_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent at one edge implies consequent at the next.
`define LSTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/lsts_pkg.sv @@
// Package for the longest-subarray block: field widths, defaults, FSM type.
// No dependencies.
package lsts_pkg;
    localparam int SUM_W         = 48;
    localparam int ELEM_W        = 32;
    localparam int LEN_W         = 11;
    localparam int MAX_ELEMS_DEF = 1024;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_INS,
        ST_EMIT
    } state_t;
endpackage

@@ design/lsts_in_if.sv @@
// Input and output channel interfaces for the longest-subarray block.
// Depends on lsts_pkg.
interface lsts_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [lsts_pkg::ELEM_W-1:0]    element_value;
    logic                                  is_last;

    modport source (output valid, element_value, is_last, input ready);
    modport sink   (input valid, element_value, is_last, output ready);
endinterface

interface lsts_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [lsts_pkg::LEN_W-1:0]            longest_length;
    logic                                  capacity_exceeded;

    modport source (output valid, longest_length, capacity_exceeded, input ready);
    modport sink   (input valid, longest_length, capacity_exceeded, output ready);
endinterface

@@ design/lsts_mem.sv @@
// Prefix-sum table: one write port, one read port, registered read data.
// No dependencies.
module lsts_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 58
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);
    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

@@ design/longest_subarray_with_target_sum_top.sv @@
// Longest subarray with target sum: top level, control FSM and datapath.
// Depends on lsts_pkg, lsts_in_if/lsts_out_if, lsts_mem and the macro header.
//
// Each beat adds element_value to a running prefix sum, then scans the table of
// distinct prefix sums seen so far (one entry per cycle through a registered
// memory read) and appends the new sum if it is new. The scan covers entry_count
// entries through the single read port of the table; entry_count is the number
// of distinct prefix sums so far, at most MAX_ELEMS. After the beat with is_last
// the block waits while an earlier result is still not taken, then emits one
// result (longest length, overflow flag) and clears the run. Elements beyond
// MAX_ELEMS are dropped and flag capacity_exceeded. target_sum is written
// through cfg_we/cfg_wdata; the user must do this only while the block is
// idle, which the block itself does not enforce.
`include "longest_subarray_with_target_sum_top_macros.svh"

module longest_subarray_with_target_sum_top #(
    parameter int MAX_ELEMS = lsts_pkg::MAX_ELEMS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [lsts_pkg::SUM_W-1:0] cfg_wdata,
    lsts_in_if.sink                    in_ch,
    lsts_out_if.source                 out_ch
);
    import lsts_pkg::*;

    localparam int IW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
    localparam int CW = $clog2(MAX_ELEMS + 1);
    localparam int DW = SUM_W + IW;

    state_t                   state_reg, state_next;
    logic signed [SUM_W-1:0]  target_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W:0]    rem_reg;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            best_reg;
    logic [CW-1:0]            ent_reg;
    logic [CW-1:0]            scan_reg;
    logic [IW-1:0]            idx_reg;
    logic                     ovf_reg;
    logic                     last_reg;
    logic                     seen_reg;
    logic                     pend_reg;
    logic                     out_valid_reg;
    logic [LEN_W-1:0]         out_len_reg;
    logic                     out_ovf_reg;

    logic                     accept;
    logic                     in_range;
    logic signed [SUM_W-1:0]  new_sum;
    logic [CW-1:0]            count_inc;
    logic                     rd_en;
    logic [DW-1:0]            rd_data;
    logic signed [SUM_W-1:0]  rd_sum;
    logic [IW-1:0]            rd_idx;
    logic [CW-1:0]            cand_len;
    logic                     hit_rem;
    logic                     hit_sum;
    logic                     scan_done;
    logic                     wr_en;
    logic                     emit_go;
    logic                     in_ready;

    assign accept    = in_ch.valid && in_ready;
    assign in_range  = count_reg < CW'(MAX_ELEMS);
    assign new_sum   = sum_reg + SUM_W'(in_ch.element_value);
    assign count_inc = count_reg + CW'(1);
    assign rd_sum    = $signed(rd_data[DW-1:IW]);
    assign rd_idx    = rd_data[IW-1:0];
    assign cand_len  = CW'(idx_reg) - CW'(rd_idx);
    assign hit_rem   = pend_reg && ((SUM_W+1)'(rd_sum) == rem_reg);
    assign hit_sum   = pend_reg && (rd_sum == sum_reg);
    assign scan_done = (scan_reg == ent_reg) && !pend_reg;
    assign emit_go   = !out_valid_reg || out_ch.ready;

    lsts_mem #(
        .DEPTH (MAX_ELEMS),
        .AW    (IW),
        .DW    (DW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (ent_reg[IW-1:0]),
        .wr_data ({sum_reg, idx_reg}),
        .rd_en   (rd_en),
        .rd_addr (scan_reg[IW-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_range)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (in_ch.is_last)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_INS;
                end
            end
            ST_INS:
            begin
                state_next = last_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        rd_en    = 1'b0;
        wr_en    = 1'b0;
        unique case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_SCAN: rd_en    = scan_reg < ent_reg;
            ST_INS:  wr_en    = !seen_reg && (ent_reg < CW'(MAX_ELEMS));
            ST_EMIT: ;
            default: ;
        endcase
    end

    assign in_ch.ready              = in_ready;
    assign out_ch.valid             = out_valid_reg;
    assign out_ch.longest_length    = out_len_reg;
    assign out_ch.capacity_exceeded = out_ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            target_reg    <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            best_reg      <= '0;
            ent_reg       <= '0;
            scan_reg      <= '0;
            ovf_reg       <= 1'b0;
            last_reg      <= 1'b0;
            seen_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= rd_en;
            if (cfg_we)
            begin
                target_reg <= $signed(cfg_wdata);
            end
            if (out_valid_reg && out_ch.ready && (state_reg != ST_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        last_reg <= in_ch.is_last;
                        if (in_range)
                        begin
                            sum_reg   <= new_sum;
                            count_reg <= count_inc;
                            scan_reg  <= '0;
                            seen_reg  <= 1'b0;
                            if (new_sum == target_reg && count_inc > best_reg)
                            begin
                                best_reg <= count_inc;
                            end
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (rd_en)
                    begin
                        scan_reg <= scan_reg + CW'(1);
                    end
                    if (hit_rem && cand_len > best_reg)
                    begin
                        best_reg <= cand_len;
                    end
                    if (hit_sum)
                    begin
                        seen_reg <= 1'b1;
                    end
                end
                ST_INS:
                begin
                    if (wr_en)
                    begin
                        ent_reg <= ent_reg + CW'(1);
                    end
                end
                ST_EMIT:
                begin
                    if (emit_go)
                    begin
                        out_valid_reg <= 1'b1;
                        sum_reg       <= '0;
                        count_reg     <= '0;
                        best_reg      <= '0;
                        ent_reg       <= '0;
                        ovf_reg       <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && accept && in_range)
        begin
            idx_reg <= count_reg[IW-1:0];
            rem_reg <= (SUM_W+1)'(new_sum) - (SUM_W+1)'(target_reg);
        end
        if (state_reg == ST_EMIT && emit_go)
        begin
            out_len_reg <= LEN_W'(best_reg);
            out_ovf_reg <= ovf_reg;
        end
    end

    `LSTS_ASSERT_ALWAYS(a_ent_le_count, ent_reg <= count_reg, "table larger than element count")
    `LSTS_ASSERT_ALWAYS(a_best_le_count, best_reg <= count_reg, "best length beyond elements")
    `LSTS_ASSERT_NEXT(a_pend_from_scan, rd_en, pend_reg && state_reg == ST_SCAN, "lost read")
    `LSTS_ASSERT_NEXT(a_emit_loads, state_reg == ST_EMIT && emit_go, out_valid_reg, "no result")
endmodule
